// File: rtl/des_pkg.sv
// ----------------------------------------------------------------------------
// DES package
// Tables, item types and permutation helpers shared by the DES block.
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int unsigned Rounds   = 16;
  localparam int unsigned HalfBits = 28;

  typedef struct packed {
    logic        func;
    logic [31:0] left;
    logic [31:0] right;
  } item_t;

  typedef logic [47:0] subkeys_t [Rounds];

  localparam int unsigned IP_TAB [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam int unsigned IPINV_TAB [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam int unsigned E_TAB [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam int unsigned P_TAB [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

  localparam int unsigned PC1_TAB [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

  localparam int unsigned PC2_TAB [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

  // Total rotation of each key half after the given round, modulo 28.
  localparam int unsigned SHIFT_TAB [Rounds] = '{
    1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,0};

  localparam logic [3:0] SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,5,6,3,11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] src);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[k] = src[IP_TAB[k] - 1];
    return r;
  endfunction

  function automatic logic [63:0] perm_ipinv(input logic [63:0] src);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[k] = src[IPINV_TAB[k] - 1];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] src);
    logic [55:0] r;
    for (int k = 0; k < 56; k++) r[k] = src[PC1_TAB[k] - 1];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] src);
    logic [47:0] r;
    for (int k = 0; k < 48; k++) r[k] = src[PC2_TAB[k] - 1];
    return r;
  endfunction

  // Rotation of a key half by a fixed amount; pure wiring.
  function automatic logic [27:0] rot28(input logic [27:0] h, input int unsigned s);
    logic [55:0] w;
    w = {h, h} >> s;
    return w[27:0];
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [5:0]  six;
    logic [3:0]  v;
    logic [31:0] s;
    logic [31:0] p;
    for (int i = 0; i < 48; i++) x[i] = r[E_TAB[i] - 1];
    x = x ^ k;
    for (int b = 0; b < 8; b++) begin
      six = x[6*b +: 6];
      v = SBOX[b][{six[0], six[5], six[1], six[2], six[3], six[4]}];
      s[4*b +: 4] = {v[0], v[1], v[2], v[3]};
    end
    for (int i = 0; i < 32; i++) p[i] = s[P_TAB[i] - 1];
    return p;
  endfunction

endpackage

// File: rtl/des_front.sv
// ----------------------------------------------------------------------------
// DES front end
// Takes requests, applies the initial permutation and holds the item.
// ----------------------------------------------------------------------------
module des_front import des_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        func_i,
  input  logic [63:0] block_in_i,
  input  logic        q_full_i,
  output logic        busy_o,
  output logic        push_o,
  output item_t       item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  [63:0] ip_w;
  logic  accept_w;

  assign push_o   = valid_q && !q_full_i;
  assign busy_o   = valid_q && q_full_i;
  assign accept_w = start_i && !busy_o;
  assign ip_w     = perm_ip(block_in_i);
  assign item_o   = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (push_o) valid_d = 1'b0;
    if (accept_w) begin
      valid_d = 1'b1;
      item_d  = '{func: func_i, left: ip_w[31:0], right: ip_w[63:32]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

// File: rtl/des_fifo.sv
// ----------------------------------------------------------------------------
// DES item queue
// Two-entry queue that decouples the front end from the round pipeline.
// ----------------------------------------------------------------------------
module des_fifo import des_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output item_t item_o
);

  item_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d  = ~wr_q;
      cnt_d = cnt_d + 2'd1;
    end
    if (pop_i) begin
      rd_d  = ~rd_q;
      cnt_d = cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

// File: rtl/des_round.sv
// ----------------------------------------------------------------------------
// DES round stage
// One registered Feistel round of the pipeline.
// ----------------------------------------------------------------------------
module des_round import des_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        last_i,
  input  logic        valid_i,
  input  item_t       item_i,
  input  logic [47:0] subkey_i,
  output logic        valid_o,
  output item_t       item_o
);

  logic        valid_q;
  item_t       item_q, item_d;
  logic [31:0] f_w;

  assign f_w = feistel(item_i.right, subkey_i);

  // The final round leaves the halves unswapped.
  always_comb begin
    item_d.func = item_i.func;
    if (last_i) begin
      item_d.left  = item_i.left ^ f_w;
      item_d.right = item_i.right;
    end else begin
      item_d.left  = item_i.right;
      item_d.right = item_i.left ^ f_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/des_back.sv
// ----------------------------------------------------------------------------
// DES back end
// Sixteen round stages followed by the registered final permutation.
// ----------------------------------------------------------------------------
module des_back import des_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  item_t       item_i,
  input  subkeys_t    subkeys_i,
  output logic        pop_o,
  output logic        done_o,
  output logic [63:0] block_out_o
);

  logic  valid_w [Rounds+1];
  item_t item_w  [Rounds+1];
  logic  done_q;
  logic  [63:0] out_q;

  // The pipeline never stalls, so the queue head is taken whenever present.
  assign pop_o      = !empty_i;
  assign valid_w[0] = !empty_i;
  assign item_w[0]  = item_i;

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    logic [47:0] key_w;
    assign key_w = item_w[r].func ? subkeys_i[Rounds-1-r] : subkeys_i[r];
    des_round u_round (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .last_i   (r == Rounds - 1),
      .valid_i  (valid_w[r]),
      .item_i   (item_w[r]),
      .subkey_i (key_w),
      .valid_o  (valid_w[r+1]),
      .item_o   (item_w[r+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_w[Rounds];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= perm_ipinv({item_w[Rounds].right, item_w[Rounds].left});
  end

  assign done_o      = done_q;
  assign block_out_o = out_q;

endmodule

// File: rtl/des_block_cipher.sv
// A request passes the front-end register, the queue, the 16 round stages and the output register.
// Throughput: one block per cycle, set by the 16 registered round stages.
// The result receiver cannot stall, so busy stays low in normal operation.
// Reset clears all valid flags and sets the key to zero; data registers are not reset.
// ----------------------------------------------------------------------------
// DES block cipher
// Single DES encrypt/decrypt with a decoupled front end and round pipeline.
// ----------------------------------------------------------------------------
module des_block_cipher import des_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        key_we_i,
  input  logic [63:0] key_i,
  input  logic        start_i,
  output logic        busy,
  input  logic        func_i,
  input  logic [63:0] block_in_i,
  output logic        done_o,
  output logic [63:0] block_out_o
);

  logic [63:0] key_q;
  logic [55:0] cd_w;
  subkeys_t    subkeys_w;
  logic        push_w, pop_w, full_w, empty_w;
  item_t       front_item_w, head_item_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (key_we_i) begin
      key_q <= key_i;
    end
  end

  // Subkey schedule is fixed wiring from the key register.
  assign cd_w = perm_pc1(key_q);
  for (genvar r = 0; r < Rounds; r++) begin : g_key
    assign subkeys_w[r] = perm_pc2({rot28(cd_w[55:28], SHIFT_TAB[r]),
                                    rot28(cd_w[27:0], SHIFT_TAB[r])});
  end

  des_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .func_i     (func_i),
    .block_in_i (block_in_i),
    .q_full_i   (full_w),
    .busy_o     (busy),
    .push_o     (push_w),
    .item_o     (front_item_w)
  );

  des_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .item_i  (front_item_w),
    .pop_i   (pop_w),
    .full_o  (full_w),
    .empty_o (empty_w),
    .item_o  (head_item_w)
  );

  des_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty_w),
    .item_i      (head_item_w),
    .subkeys_i   (subkeys_w),
    .pop_o       (pop_w),
    .done_o      (done_o),
    .block_out_o (block_out_o)
  );

endmodule

// File: rtl/des_checker.sv
// ----------------------------------------------------------------------------
// DES port checker
// Timing checks on the top-level ports, bound to the cipher.
// ----------------------------------------------------------------------------
module des_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy,
  input logic done_o
);

  // The pipeline drains every cycle, so the front end never backs up.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 19))
    else $error("result without a request");

  a_request_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy) |-> ##19 done_o)
    else $error("request lost");

endmodule

bind des_block_cipher des_checker u_des_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy    (busy),
  .done_o  (done_o)
);
